### rtl/osp_pkg.sv
// Shared types and constants for the meter OBIS stream parser.
package osp_pkg;

	typedef enum logic [3:0] {
		PH_HUNT  = 4'd0,
		PH_GOT9  = 4'd1,
		PH_GOT6  = 4'd2,
		PH_GOT61 = 4'd3,
		PH_CODE  = 4'd4,
		PH_SKIP  = 4'd5,
		PH_HIGH  = 4'd6,
		PH_LOW   = 4'd7,
		PH_VAL8  = 4'd8
	} phase_t;

	localparam logic [3:0] KIND_NONE   = 4'd0;
	localparam logic [3:0] KIND_POWER  = 4'd1;
	localparam logic [3:0] KIND_CUR1   = 4'd2;
	localparam logic [3:0] KIND_CUR2   = 4'd3;
	localparam logic [3:0] KIND_CUR3   = 4'd4;
	localparam logic [3:0] KIND_VOLT1  = 4'd5;
	localparam logic [3:0] KIND_VOLT2  = 4'd6;
	localparam logic [3:0] KIND_VOLT3  = 4'd7;
	localparam logic [3:0] KIND_SILENT = 4'd8;

	localparam logic [7:0] BYTE_START0 = 8'd9;
	localparam logic [7:0] BYTE_START1 = 8'd6;
	localparam logic [7:0] SEL_CLOCK   = 8'd0;
	localparam logic [7:0] SEL_OBIS    = 8'd1;

	localparam logic [7:0] CODE_ZERO   = 8'd0;
	localparam logic [7:0] CODE_POWER  = 8'd1;
	localparam logic [7:0] CODE_SIL_A  = 8'd2;
	localparam logic [7:0] CODE_SIL_B  = 8'd3;
	localparam logic [7:0] CODE_SIL_C  = 8'd4;
	localparam logic [7:0] CODE_CUR1   = 8'd31;
	localparam logic [7:0] CODE_CUR2   = 8'd51;
	localparam logic [7:0] CODE_CUR3   = 8'd71;
	localparam logic [7:0] CODE_VOLT1  = 8'd32;
	localparam logic [7:0] CODE_VOLT2  = 8'd52;
	localparam logic [7:0] CODE_VOLT3  = 8'd72;
	localparam logic [7:0] CODE_INFO   = 8'd96;

	localparam logic [3:0] SKIP_CLOCK = 4'd13;
	localparam logic [3:0] SKIP_SHORT = 4'd2;
	localparam logic [3:0] SKIP_WORD  = 4'd6;
	localparam logic [3:0] SKIP_BYTE  = 4'd5;

	localparam logic [1:0] CFG_POWER_LIMIT   = 2'd0;
	localparam logic [1:0] CFG_CURRENT_LIMIT = 2'd1;
	localparam logic [1:0] CFG_VOLTAGE_LIMIT = 2'd2;

	localparam logic [15:0] POWER_LIMIT_RST   = 16'd20000;
	localparam logic [15:0] CURRENT_LIMIT_RST = 16'd6000;
	localparam logic [7:0]  VOLTAGE_LIMIT_RST = 8'd251;

	localparam logic signed [1:0] SCALE_CURRENT = -2'sd2;
	localparam logic signed [1:0] SCALE_UNIT    = 2'sd0;

	typedef struct packed {
		logic [15:0] power;
		logic [15:0] current;
		logic [7:0]  voltage;
	} limits_t;

	typedef struct packed {
		logic               valid;
		logic [2:0]         quantity;
		logic [15:0]        reading;
		logic signed [1:0]  scale_exp;
	} result_t;

endpackage

### rtl/osp_cfg_regs.sv
// Limit registers written through the configuration channel.
module osp_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	output osp_pkg::limits_t limits
);
	import osp_pkg::*;

	limits_t limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.power   <= POWER_LIMIT_RST;
			limits_q.current <= CURRENT_LIMIT_RST;
			limits_q.voltage <= VOLTAGE_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_POWER_LIMIT:   limits_q.power   <= cfg_data;
				CFG_CURRENT_LIMIT: limits_q.current <= cfg_data;
				CFG_VOLTAGE_LIMIT: limits_q.voltage <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign limits = limits_q;

endmodule

### rtl/osp_parser.sv
// Parse state machine: consumes one byte per step and forms at most one result.
module osp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  osp_pkg::limits_t limits,
	output osp_pkg::result_t result
);
	import osp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  skip_q, skip_d;
	logic [3:0]  kind_q, kind_d;
	logic [7:0]  high_q, high_d;
	logic [3:0]  skip_dec;
	logic [15:0] value;
	logic [15:0] limit;
	logic        kind_ok;
	logic        is_current;

	assign skip_dec = skip_q - 4'd1;

	always_comb begin
		phase_d = phase_q;
		skip_d  = skip_q;
		kind_d  = kind_q;
		high_d  = high_q;
		case (phase_q)
			PH_GOT9: begin
				if (rx_byte == BYTE_START1) begin
					phase_d = PH_GOT6;
				end else begin
					phase_d = PH_HUNT;
					skip_d  = '0;
					kind_d  = KIND_NONE;
				end
			end
			PH_GOT6: begin
				if (rx_byte == SEL_CLOCK) begin
					phase_d = PH_SKIP;
					skip_d  = SKIP_CLOCK;
					kind_d  = KIND_NONE;
				end else if (rx_byte == SEL_OBIS) begin
					phase_d = PH_GOT61;
				end else begin
					phase_d = PH_HUNT;
					skip_d  = '0;
					kind_d  = KIND_NONE;
				end
			end
			PH_GOT61: begin
				if (rx_byte == SEL_OBIS) begin
					phase_d = PH_CODE;
				end else begin
					phase_d = PH_HUNT;
					skip_d  = '0;
					kind_d  = KIND_NONE;
				end
			end
			PH_CODE: begin
				phase_d = PH_SKIP;
				case (rx_byte)
					CODE_ZERO, CODE_INFO: begin
						skip_d = SKIP_SHORT;
						kind_d = KIND_NONE;
					end
					CODE_POWER: begin
						skip_d = SKIP_WORD;
						kind_d = KIND_POWER;
					end
					CODE_SIL_A, CODE_SIL_B, CODE_SIL_C: begin
						skip_d = SKIP_WORD;
						kind_d = KIND_SILENT;
					end
					CODE_CUR1: begin
						skip_d = SKIP_WORD;
						kind_d = KIND_CUR1;
					end
					CODE_CUR2: begin
						skip_d = SKIP_WORD;
						kind_d = KIND_CUR2;
					end
					CODE_CUR3: begin
						skip_d = SKIP_WORD;
						kind_d = KIND_CUR3;
					end
					CODE_VOLT1: begin
						skip_d = SKIP_BYTE;
						kind_d = KIND_VOLT1;
					end
					CODE_VOLT2: begin
						skip_d = SKIP_BYTE;
						kind_d = KIND_VOLT2;
					end
					CODE_VOLT3: begin
						skip_d = SKIP_BYTE;
						kind_d = KIND_VOLT3;
					end
					default: begin
						phase_d = PH_HUNT;
						skip_d  = '0;
						kind_d  = KIND_NONE;
					end
				endcase
			end
			PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 4'd0) begin
					if (kind_q == KIND_NONE) begin
						phase_d = PH_HUNT;
						kind_d  = KIND_NONE;
					end else if (kind_q >= KIND_VOLT1 && kind_q <= KIND_VOLT3) begin
						phase_d = PH_VAL8;
					end else begin
						phase_d = PH_HIGH;
					end
				end
			end
			PH_HIGH: begin
				high_d  = rx_byte;
				phase_d = PH_LOW;
			end
			PH_LOW, PH_VAL8: begin
				phase_d = PH_HUNT;
				skip_d  = '0;
				kind_d  = KIND_NONE;
			end
			default: begin
				skip_d  = '0;
				kind_d  = KIND_NONE;
				phase_d = (rx_byte == BYTE_START0) ? PH_GOT9 : PH_HUNT;
			end
		endcase
	end

	always_comb begin
		value      = (phase_q == PH_LOW) ? {high_q, rx_byte} : {8'd0, rx_byte};
		is_current = (kind_q >= KIND_CUR1) && (kind_q <= KIND_CUR3);
		kind_ok    = (kind_q >= KIND_POWER) && (kind_q <= KIND_VOLT3);
		if (kind_q == KIND_POWER) begin
			limit = limits.power;
		end else if (is_current) begin
			limit = limits.current;
		end else begin
			limit = {8'd0, limits.voltage};
		end
		result.valid     = step && ((phase_q == PH_LOW) || (phase_q == PH_VAL8))
			&& kind_ok && (value <= limit);
		result.quantity  = 3'(kind_q - KIND_POWER);
		result.reading   = value;
		result.scale_exp = is_current ? SCALE_CURRENT : SCALE_UNIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			skip_q  <= '0;
			kind_q  <= KIND_NONE;
			high_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			skip_q  <= skip_d;
			kind_q  <= kind_d;
			high_q  <= high_d;
		end
	end

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (skip_q != 4'd0))
		else $error("skip phase with empty skip count");

	a_val8_voltage: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_VAL8) |-> (kind_q >= KIND_VOLT1 && kind_q <= KIND_VOLT3))
		else $error("single byte value without voltage kind");

	a_hunt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT) |-> (kind_q == KIND_NONE && skip_q == 4'd0))
		else $error("hunting with stale kind or skip count");

endmodule

### rtl/meter_obis_stream_parser_top.sv
// Top level of the meter OBIS stream parser: input stage, parser, result register.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one byte of the meter
//   stream per item. The output channel (out_valid/out_ready) delivers
//   quantity, reading and scale_exp for each reading that is within its limit.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   writes power_limit (0), current_limit (1) and voltage_limit (2); other
//   indexes are ignored. cfg_ready is always high.
//   A result is registered: the last byte of its reading first sits in the
//   input register, and the parse step then loads the result register from
//   it, which can wait while the receiver stalls.
//   Throughput: one byte per cycle while the receiver does not stall, set by
//   the single parse step between the input register and the result register.
//   When the receiver stalls with a result pending, an empty input register
//   still takes a byte; a full one drops in_ready until the result is taken.
//   Reset clears both stages, returns the parser to hunting for the start pair
//   and loads the limit registers with 20000, 6000 and 251.
module meter_obis_stream_parser_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        quantity,
	output logic [15:0]       reading,
	output logic signed [1:0] scale_exp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import osp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        step;
	limits_t     limits;
	result_t     result;
	logic        out_valid_q;
	logic [2:0]  quantity_q;
	logic [15:0] reading_q;
	logic signed [1:0] scale_q;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || out_ready;
	assign step      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;

	osp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.limits    (limits)
	);

	osp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.limits  (limits),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			quantity_q <= result.quantity;
			reading_q  <= result.reading;
			scale_q    <= result.scale_exp;
		end
	end

	assign out_valid = out_valid_q;
	assign quantity  = quantity_q;
	assign reading   = reading_q;
	assign scale_exp = scale_q;

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a pending result");

	a_byte_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled byte lost or changed");

	a_quantity_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (quantity_q <= 3'd6))
		else $error("quantity out of range");

	a_scale_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((scale_q == SCALE_CURRENT) ==
			(quantity_q >= 3'd1 && quantity_q <= 3'd3)))
		else $error("scale does not match quantity");

endmodule
